// ----- src/fmrb_pkg.sv -----
// ----------------------------------------------------------------------------
// fmrb_pkg: shared types and constants for the framed mailbox ring buffer
// Command and status codes, ring geometry and the request/response items.
// ----------------------------------------------------------------------------
`default_nettype none

package fmrb_pkg;

  localparam int MEM_BYTES  = 4096;
  localparam int HEAD_BYTES = 12;
  localparam int PTR_W      = $clog2(MEM_BYTES);
  localparam int LEFT_W     = PTR_W + 1;

  localparam logic [PTR_W-1:0] RING_LOW  = PTR_W'(HEAD_BYTES);
  localparam logic [PTR_W-1:0] RING_HIGH = PTR_W'(MEM_BYTES - HEAD_BYTES);
  localparam logic [PTR_W:0]   RING_SIZE = (PTR_W + 1)'(MEM_BYTES - 2 * HEAD_BYTES);

  localparam logic [7:0] END_MARK  = 8'h7e;
  localparam logic [7:0] FILL_MARK = 8'ha5;

  localparam logic [1:0] CMD_OPEN  = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_SPACE = 3'd1;
  localparam logic [2:0] ST_NO_OPEN  = 3'd2;
  localparam logic [2:0] ST_EMPTY    = 3'd3;
  localparam logic [2:0] ST_BUSY     = 3'd4;

  typedef struct packed {
    logic [1:0]  command;
    logic [11:0] write_length;
    logic [7:0]  write_data;
  } req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  read_data;
    logic        frame_end;
    logic        frame_ok;
    logic        write_done;
    logic [11:0] write_position;
    logic [11:0] read_position;
  } rsp_t;

endpackage

`default_nettype wire

// ----- src/fmrb_ram.sv -----
// ----------------------------------------------------------------------------
// fmrb_ram: generic single-write, single-read RAM
// One write port and one read port with registered, enabled read data.
// ----------------------------------------------------------------------------
`default_nettype none

module fmrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

// ----- src/framed_mailbox_ring_buffer_unit.sv -----
// ----------------------------------------------------------------------------
// framed_mailbox_ring_buffer_unit: framed byte ring between two processors
// Usage: commands enter on the req channel (valid/stall), one response per
// command leaves on the rsp channel. Commands: open a packet write of a given
// length (checked against free space), write one byte, read one byte. Reads
// advance a tentative pointer; when it reaches the write pointer the frame is
// checked (first byte not 0x00/0xa5, last byte 0x7e) and either committed or
// rolled back.
// Timing: a command accepted into the input register has its response
// registered when it advances. One command per cycle is sustained unless
// rsp_stall holds a response; the ring RAM read is issued at acceptance
// with the pointer forwarded from the command still in the input register.
// Reset: pointers return to the ring base, no write is open, no frame is in
// progress; ring contents are not cleared.
// Stall: while rsp_stall holds a pending response, the input register holds
// too and req_stall rises once the input register is occupied.
// ----------------------------------------------------------------------------
`default_nettype none

module framed_mailbox_ring_buffer_unit (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          req_valid,
  output logic               req_stall,
  input  wire fmrb_pkg::req_t req,
  output logic               rsp_valid,
  input  wire logic          rsp_stall,
  output fmrb_pkg::rsp_t     rsp
);

  localparam int PW = fmrb_pkg::PTR_W;
  localparam int LW = fmrb_pkg::LEFT_W;

  function automatic logic [PW-1:0] next_pos(input logic [PW-1:0] p);
    logic [PW:0] s;
    s = {1'b0, p} + 1'b1;
    if (s >= {1'b0, fmrb_pkg::RING_HIGH}) begin
      return fmrb_pkg::RING_LOW;
    end
    return s[PW-1:0];
  endfunction

  // state as seen before the item in the input register
  logic [PW-1:0] wp, crp, trp;
  logic [LW-1:0] left;
  logic [7:0]    ffb;
  logic          fstarted;

  logic [PW-1:0] wp_next, crp_next, trp_next;
  logic [LW-1:0] left_next;
  logic [7:0]    ffb_next;
  logic          fstarted_next;

  logic           item_valid;
  fmrb_pkg::req_t item;
  fmrb_pkg::rsp_t res;
  logic [7:0]     ram_q;

  logic          accept;
  logic          advance;
  logic [PW:0]   used, room;
  logic [PW-1:0] t1;
  logic [7:0]    first;
  logic          good;

  assign advance   = item_valid && !(rsp_valid && rsp_stall);
  assign req_stall = item_valid && rsp_valid && rsp_stall;
  assign accept    = req_valid && !req_stall;

  always_comb begin
    wp_next       = wp;
    crp_next      = crp;
    trp_next      = trp;
    left_next     = left;
    ffb_next      = ffb;
    fstarted_next = fstarted;
    res           = '0;
    t1            = next_pos(trp);
    first         = fstarted ? ffb : ram_q;
    good          = (first != 8'h00) && (first != fmrb_pkg::FILL_MARK) &&
                    (ram_q == fmrb_pkg::END_MARK);
    if (wp >= crp) begin
      used = {1'b0, wp - crp};
    end else begin
      used = fmrb_pkg::RING_SIZE - {1'b0, crp - wp};
    end
    if (fmrb_pkg::RING_SIZE > used + 1'b1) begin
      room = fmrb_pkg::RING_SIZE - 1'b1 - used;
    end else begin
      room = '0;
    end
    if (item_valid) begin
      case (item.command)
        fmrb_pkg::CMD_OPEN: begin
          if (left != '0) begin
            res.status = fmrb_pkg::ST_BUSY;
          end else if ({1'b0, item.write_length} > room) begin
            res.status = fmrb_pkg::ST_NO_SPACE;
          end else begin
            left_next = LW'(item.write_length);
          end
        end
        fmrb_pkg::CMD_WRITE: begin
          if (left == '0) begin
            res.status = fmrb_pkg::ST_NO_OPEN;
          end else begin
            wp_next        = next_pos(wp);
            left_next      = left - 1'b1;
            res.write_done = (left == LW'(1));
          end
        end
        fmrb_pkg::CMD_READ: begin
          if (trp == wp) begin
            res.status = fmrb_pkg::ST_EMPTY;
          end else begin
            res.read_data = ram_q;
            if (t1 == wp) begin
              res.frame_end = 1'b1;
              res.frame_ok  = good;
              fstarted_next = 1'b0;
              if (good) begin
                crp_next = t1;
                trp_next = t1;
              end else begin
                trp_next = crp;
              end
            end else begin
              trp_next      = t1;
              ffb_next      = first;
              fstarted_next = 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
    res.write_position = wp_next;
    res.read_position  = crp_next;
  end

  fmrb_ram #(
    .WIDTH (8),
    .DEPTH (fmrb_pkg::MEM_BYTES)
  ) u_ram (
    .clk   (clk),
    .we    (accept && req.command == fmrb_pkg::CMD_WRITE && left_next != '0),
    .waddr (wp_next),
    .wdata (req.write_data),
    .re    (accept && req.command == fmrb_pkg::CMD_READ),
    .raddr (trp_next),
    .rdata (ram_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wp         <= fmrb_pkg::RING_LOW;
      crp        <= fmrb_pkg::RING_LOW;
      trp        <= fmrb_pkg::RING_LOW;
      left       <= '0;
      ffb        <= '0;
      fstarted   <= 1'b0;
      item_valid <= 1'b0;
      rsp_valid  <= 1'b0;
    end else begin
      if (advance) begin
        wp       <= wp_next;
        crp      <= crp_next;
        trp      <= trp_next;
        left     <= left_next;
        ffb      <= ffb_next;
        fstarted <= fstarted_next;
      end
      if (!req_stall) begin
        item_valid <= req_valid;
      end
      if (advance) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= req;
    end
    if (advance) begin
      rsp <= res;
    end
  end

endmodule

`default_nettype wire

// ----- tb/tb_framed_mailbox_ring_buffer_unit.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_framed_mailbox_ring_buffer_unit: self-checking bench for the framed ring
// Drives open, write, read and spare command items through the req channel.
// A local copy of the ring, pointers and frame state predicts each response.
// Responses are checked in order. Tests run in this order:
//   - corner items
//   - receiver hold-off and sender pause
//   - random framed traffic mixed with noise
//   - a frame whose leading byte can never pass the frame check
// ----------------------------------------------------------------------------

module tb_framed_mailbox_ring_buffer_unit;

  localparam logic [1:0] CMD_SPARE   = 2'd3;
  localparam int         CYCLE_LIMIT = 1_000_000;

  logic clk = 1'b0;
  logic rst;
  logic req_valid;
  logic req_stall;
  fmrb_pkg::req_t req;
  logic rsp_valid;
  logic rsp_stall = 1'b0;
  fmrb_pkg::rsp_t rsp;

  framed_mailbox_ring_buffer_unit uut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // ring image and pointers as the block should hold them
  logic [7:0]                  ring_image [fmrb_pkg::MEM_BYTES];
  logic [fmrb_pkg::PTR_W-1:0]  wr_pos     = fmrb_pkg::RING_LOW;
  logic [fmrb_pkg::PTR_W-1:0]  rd_commit  = fmrb_pkg::RING_LOW;
  logic [fmrb_pkg::PTR_W-1:0]  rd_probe   = fmrb_pkg::RING_LOW;
  logic [fmrb_pkg::LEFT_W-1:0] bytes_owed = '0;
  logic [7:0]                  lead_seen  = '0;
  logic                        frame_open = 1'b0;

  fmrb_pkg::rsp_t replies_due [$];
  fmrb_pkg::rsp_t last_rsp;
  fmrb_pkg::rsp_t due;
  int   work_items  = 0;
  int   mismatches  = 0;
  int   cycle_count = 0;
  int   gap_pct     = 0;
  int   stall_pct   = 0;
  int   stall_run   = 0;
  int   hold_cycles = 0;

  function automatic logic [fmrb_pkg::PTR_W-1:0] step_pos(logic [fmrb_pkg::PTR_W-1:0] p);
    int n;
    n = int'(p) + 1;
    if (n >= int'(fmrb_pkg::RING_HIGH)) return fmrb_pkg::RING_LOW;
    return fmrb_pkg::PTR_W'(n);
  endfunction

  function automatic int free_room();
    int used;
    if (wr_pos >= rd_commit) used = int'(wr_pos) - int'(rd_commit);
    else used = int'(fmrb_pkg::RING_SIZE) - (int'(rd_commit) - int'(wr_pos));
    return (int'(fmrb_pkg::RING_SIZE) > used + 1) ? int'(fmrb_pkg::RING_SIZE) - 1 - used : 0;
  endfunction

  function automatic fmrb_pkg::rsp_t advance_ring(fmrb_pkg::req_t item);
    fmrb_pkg::rsp_t r;
    r = '0;
    r.status = fmrb_pkg::ST_OK;
    case (item.command)
      fmrb_pkg::CMD_OPEN: begin
        if (bytes_owed != 0) r.status = fmrb_pkg::ST_BUSY;
        else if (int'(item.write_length) > free_room()) r.status = fmrb_pkg::ST_NO_SPACE;
        else bytes_owed = fmrb_pkg::LEFT_W'(item.write_length);
      end
      fmrb_pkg::CMD_WRITE: begin
        if (bytes_owed == 0) begin
          r.status = fmrb_pkg::ST_NO_OPEN;
        end else begin
          ring_image[wr_pos] = item.write_data;
          wr_pos = step_pos(wr_pos);
          bytes_owed = bytes_owed - 1'b1;
          r.write_done = (bytes_owed == 0);
        end
      end
      fmrb_pkg::CMD_READ: begin
        if (rd_probe == wr_pos) begin
          r.status = fmrb_pkg::ST_EMPTY;
        end else begin
          r.read_data = ring_image[rd_probe];
          if (!frame_open) begin
            lead_seen = r.read_data;
            frame_open = 1'b1;
          end
          rd_probe = step_pos(rd_probe);
          if (rd_probe == wr_pos) begin
            r.frame_end = 1'b1;
            r.frame_ok = lead_seen != 8'h00 && lead_seen != fmrb_pkg::FILL_MARK &&
                         r.read_data == fmrb_pkg::END_MARK;
            if (r.frame_ok) rd_commit = rd_probe;
            else rd_probe = rd_commit;
            frame_open = 1'b0;
          end
        end
      end
      default: ;
    endcase
    r.write_position = wr_pos;
    r.read_position = rd_commit;
    return r;
  endfunction

  function automatic fmrb_pkg::req_t mk_item(logic [1:0] cmd, int len, int data);
    fmrb_pkg::req_t r;
    r.command = cmd;
    r.write_length = 12'(len);
    r.write_data = 8'(data);
    return r;
  endfunction

  // any byte that may lead a frame
  function automatic logic [7:0] lead_byte();
    logic [7:0] b;
    do b = 8'($urandom_range(1, 255)); while (b == fmrb_pkg::FILL_MARK);
    return b;
  endfunction

  task automatic send_item(input fmrb_pkg::req_t item);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      req_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    req_valid <= 1'b1;
    req <= item;
    do @(posedge clk); while (req_stall);
    last_rsp = advance_ring(item);
    replies_due.push_back(last_rsp);
    if (last_rsp.status == fmrb_pkg::ST_OK && item.command != CMD_SPARE) work_items++;
  endtask

  task automatic drain_results();
    req_valid <= 1'b0;
    do @(posedge clk); while (replies_due.size() != 0);
  endtask

  task automatic write_packet(input int count, input logic [7:0] lead, input bit tail_ok);
    logic [7:0] b;
    send_item(mk_item(fmrb_pkg::CMD_OPEN, count, $urandom));
    if (last_rsp.status == fmrb_pkg::ST_OK) begin
      for (int i = 0; i < count; i++) begin
        if (i == count - 1 && tail_ok) b = fmrb_pkg::END_MARK;
        else if (i == 0) b = lead;
        else b = 8'($urandom);
        send_item(mk_item(fmrb_pkg::CMD_WRITE, $urandom, b));
      end
    end
  endtask

  // completes an open packet; a byte landing at the committed pointer leads a frame
  task automatic finish_packet();
    logic [7:0] b;
    while (bytes_owed != 0) begin
      if (bytes_owed == 1) b = fmrb_pkg::END_MARK;
      else if (wr_pos == rd_commit) b = lead_byte();
      else b = 8'($urandom_range(0, 255));
      send_item(mk_item(fmrb_pkg::CMD_WRITE, $urandom, b));
    end
  endtask

  task automatic read_frame();
    do send_item(mk_item(fmrb_pkg::CMD_READ, $urandom, $urandom));
    while (last_rsp.status == fmrb_pkg::ST_OK && !last_rsp.frame_end);
  endtask

  task automatic test_corner_items();
    gap_pct = 0;
    stall_pct = 0;
    send_item(mk_item(fmrb_pkg::CMD_READ, 12'hfff, 8'hff));
    send_item(mk_item(fmrb_pkg::CMD_WRITE, 12'hfff, 8'hff));
    send_item(mk_item(CMD_SPARE, 12'hfff, 8'hff));
    send_item(mk_item(fmrb_pkg::CMD_OPEN, 0, 0));
    send_item(mk_item(fmrb_pkg::CMD_WRITE, 0, 8'h7e));
    send_item(mk_item(fmrb_pkg::CMD_OPEN, 12'hfff, 0));
    send_item(mk_item(fmrb_pkg::CMD_OPEN, int'(fmrb_pkg::RING_SIZE), 0));
    send_item(mk_item(fmrb_pkg::CMD_OPEN, 4, 0));
    send_item(mk_item(fmrb_pkg::CMD_OPEN, 2, 0));
    send_item(mk_item(fmrb_pkg::CMD_WRITE, 0, 8'hff));
    send_item(mk_item(fmrb_pkg::CMD_WRITE, 0, fmrb_pkg::FILL_MARK));
    send_item(mk_item(fmrb_pkg::CMD_WRITE, 0, 8'h00));
    send_item(mk_item(fmrb_pkg::CMD_WRITE, 0, fmrb_pkg::END_MARK));
    read_frame();
    // bad tail rolls back, appending an end mark later commits it all
    send_item(mk_item(fmrb_pkg::CMD_OPEN, 2, 0));
    send_item(mk_item(fmrb_pkg::CMD_WRITE, 0, 8'h5a));
    send_item(mk_item(fmrb_pkg::CMD_WRITE, 0, 8'h01));
    read_frame();
    send_item(mk_item(fmrb_pkg::CMD_READ, 0, 0));
    send_item(mk_item(fmrb_pkg::CMD_OPEN, 1, 0));
    send_item(mk_item(fmrb_pkg::CMD_WRITE, 0, fmrb_pkg::END_MARK));
    read_frame();
    send_item(mk_item(fmrb_pkg::CMD_READ, 0, 0));
  endtask

  task automatic test_backpressure();
    gap_pct = 0;
    stall_pct = 0;
    hold_cycles = 80;
    write_packet(20, lead_byte(), 1'b1);
    read_frame();
    drain_results();
    write_packet(5, lead_byte(), 1'b1);
    read_frame();
  endtask

  task automatic test_random_traffic();
    int goal;
    int len;
    logic [1:0] cmd;
    logic [7:0] b;
    goal = work_items + 560;
    gap_pct = 25;
    stall_pct = 25;
    while (work_items < goal) begin
      if ($urandom_range(0, 39) == 0) gap_pct = (gap_pct != 0) ? 0 : 25;
      if ($urandom_range(0, 39) == 0) stall_pct = (stall_pct != 0) ? 0 : 25;
      if ($urandom_range(0, 9) < 7) begin
        finish_packet();
        len = ($urandom_range(0, 15) == 0) ? $urandom_range(17, 200) : $urandom_range(1, 16);
        write_packet(len, lead_byte(), $urandom_range(0, 7) != 0);
        if ($urandom_range(0, 2) != 0) read_frame();
      end else begin
        cmd = 2'($urandom_range(0, 3));
        if (cmd == fmrb_pkg::CMD_OPEN && $urandom_range(0, 39) != 0) len = $urandom_range(0, 40);
        else len = $urandom_range(0, 4095);
        b = (cmd == fmrb_pkg::CMD_WRITE && wr_pos == rd_commit) ? lead_byte() : 8'($urandom);
        send_item(mk_item(cmd, len, b));
      end
    end
  endtask

  // run last: a frame led by 0x00 or 0xa5 never commits
  task automatic test_bad_lead();
    gap_pct = 0;
    stall_pct = 0;
    finish_packet();
    if (wr_pos != rd_commit) begin
      read_frame();
      if (!last_rsp.frame_ok) begin
        write_packet(1, fmrb_pkg::END_MARK, 1'b1);
        read_frame();
      end
    end
    write_packet(3, $urandom_range(0, 1) ? fmrb_pkg::FILL_MARK : 8'h00, 1'b1);
    read_frame();
    read_frame();
    send_item(mk_item(fmrb_pkg::CMD_OPEN, 2, 0));
    send_item(mk_item(fmrb_pkg::CMD_WRITE, 0, 8'h33));
    send_item(mk_item(fmrb_pkg::CMD_WRITE, 0, fmrb_pkg::END_MARK));
    read_frame();
  endtask

  always @(posedge clk) begin
    if (hold_cycles != 0) begin
      rsp_stall <= 1'b1;
      hold_cycles = hold_cycles - 1;
    end else if (stall_run != 0) begin
      rsp_stall <= 1'b1;
      stall_run = stall_run - 1;
    end else if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
      rsp_stall <= 1'b1;
      stall_run = $urandom_range(1, 11) - 1;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    if (!rst && rsp_valid && !rsp_stall) begin
      if (replies_due.size() == 0) begin
        if (mismatches < 10)
          $display("unexpected item: st=%0d rd=%h end=%b ok=%b done=%b wp=%0d rp=%0d",
                   rsp.status, rsp.read_data, rsp.frame_end, rsp.frame_ok,
                   rsp.write_done, rsp.write_position, rsp.read_position);
        mismatches++;
      end else begin
        due = replies_due.pop_front();
        if (rsp.status !== due.status || rsp.read_data !== due.read_data ||
            rsp.frame_end !== due.frame_end || rsp.frame_ok !== due.frame_ok ||
            rsp.write_done !== due.write_done ||
            rsp.write_position !== due.write_position ||
            rsp.read_position !== due.read_position) begin
          if (mismatches < 10) begin
            $display("mismatch: want st=%0d rd=%h end=%b ok=%b done=%b wp=%0d rp=%0d",
                     due.status, due.read_data, due.frame_end, due.frame_ok,
                     due.write_done, due.write_position, due.read_position);
            $display("           got st=%0d rd=%h end=%b ok=%b done=%b wp=%0d rp=%0d",
                     rsp.status, rsp.read_data, rsp.frame_end, rsp.frame_ok,
                     rsp.write_done, rsp.write_position, rsp.read_position);
          end
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    rst = 1'b1;
    req_valid = 1'b0;
    req = '0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_corner_items();
    test_backpressure();
    test_random_traffic();
    test_bad_lead();
    drain_results();
    repeat (4) @(posedge clk);
    if (mismatches == 0 && replies_due.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
